// ----- hw/rtl/lcg64_pkg.sv -----
`timescale 1ns / 1ps

package lcg64_pkg;

  // Affine step constants: S' = S * LcgMul + LcgAdd (mod 2^64)
  localparam logic [63:0] LcgMul = 64'd1812433253;
  localparam logic [63:0] LcgAdd = 64'd123456789;

  // Seed-more mixing rotation
  localparam int unsigned RotLeft = 5;

  typedef enum logic [2:0] {
    CMD_SEED      = 3'd0,
    CMD_SEED_MORE = 3'd1,
    CMD_DRAW32    = 3'd2,
    CMD_DRAW64    = 3'd3,
    CMD_BOUNDED   = 3'd4,
    CMD_JUMP      = 3'd5
  } cmd_e;

  // Request to the shared multiply-add unit: result = a * b + c (mod 2^64)
  typedef struct packed {
    logic        start;
    logic [63:0] a;
    logic [63:0] b;
    logic [63:0] c;
  } mac_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] result;
  } mac_rsp_t;

endpackage

// ----- hw/rtl/lcg64_in_if.sv -----
`timescale 1ns / 1ps

interface lcg64_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  command;
  logic [31:0] seed_word;
  logic [31:0] range_limit;
  logic [63:0] jump_count;

  modport source (
    output valid, command, seed_word, range_limit, jump_count,
    input  ready
  );

  modport sink (
    input  valid, command, seed_word, range_limit, jump_count,
    output ready
  );
endinterface

// ----- hw/rtl/lcg64_out_if.sv -----
`timescale 1ns / 1ps

interface lcg64_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] random_value;

  modport source (
    output valid, random_value,
    input  ready
  );

  modport sink (
    input  valid, random_value,
    output ready
  );
endinterface

// ----- hw/rtl/lcg64_mac.sv -----
`timescale 1ns / 1ps

// 64-bit multiply-add modulo 2^64 on one 32x32 multiplier, three passes.
module lcg64_mac
  import lcg64_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  mac_req_t req_i,
  output mac_rsp_t rsp_o
);

  typedef enum logic [3:0] {
    PH_IDLE = 4'b0001,
    PH_LL   = 4'b0010,
    PH_LH   = 4'b0100,
    PH_HL   = 4'b1000
  } phase_e;

  phase_e      phase_q, phase_d;
  logic        done_q, done_d;
  logic [63:0] a_q, b_q, c_q, acc_q, acc_d;
  logic [31:0] mul_a, mul_b;
  logic [63:0] prod;

  // Pick the partial product for this pass
  always_comb begin
    case (phase_q)
      PH_LL:   begin mul_a = a_q[31:0];  mul_b = b_q[31:0];  end
      PH_LH:   begin mul_a = a_q[31:0];  mul_b = b_q[63:32]; end
      PH_HL:   begin mul_a = a_q[63:32]; mul_b = b_q[31:0];  end
      default: begin mul_a = '0;         mul_b = '0;         end
    endcase
  end

  assign prod = {32'd0, mul_a} * {32'd0, mul_b};

  // Accumulate; the high-half cross terms only reach the upper word
  always_comb begin
    phase_d = phase_q;
    done_d  = 1'b0;
    acc_d   = acc_q;
    case (phase_q)
      PH_IDLE: if (req_i.start) phase_d = PH_LL;
      PH_LL: begin
        acc_d   = prod + c_q;
        phase_d = PH_LH;
      end
      PH_LH: begin
        acc_d   = acc_q + {prod[31:0], 32'd0};
        phase_d = PH_HL;
      end
      PH_HL: begin
        acc_d   = acc_q + {prod[31:0], 32'd0};
        phase_d = PH_IDLE;
        done_d  = 1'b1;
      end
      default: phase_d = PH_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      done_q  <= 1'b0;
    end else begin
      phase_q <= phase_d;
      done_q  <= done_d;
    end
  end

  // Latch operands on start; hold the accumulator between passes
  always_ff @(posedge clk_i) begin
    if (phase_q == PH_IDLE && req_i.start) begin
      a_q <= req_i.a;
      b_q <= req_i.b;
      c_q <= req_i.c;
    end
    acc_q <= acc_d;
  end

  assign rsp_o.done   = done_q;
  assign rsp_o.result = acc_q;

  a_done_after_hl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(phase_q == PH_HL))
    else $error("multiply-add done without a final pass");

  a_no_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_LL) |=> (phase_q == PH_LH))
    else $error("multiply-add pass sequence broken");

  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q)
    else $error("multiply-add done held for more than one cycle");

endmodule

// ----- hw/rtl/lcg64_random_generator_with_jump_core.sv -----
`timescale 1ns / 1ps

// 64-bit linear congruential generator with jump-ahead.
// Input channel in_i carries one command per transaction: seed, seed-more,
// draw32, draw64, bounded draw or jump, with seed_word, range_limit and
// jump_count alongside. Draw commands return one transaction on out_o
// (random_value, 32-bit draws zero-extended); the other commands return none.
// Every state step, bounded product and jump powering term goes through one
// shared multiply-add unit built on a single 32x32 multiplier, three passes
// per 64-bit multiply-add. Jump walks jump_count from its lowest bit, applying
// the current power to the state for each set bit and squaring the power for
// each bit below the highest set bit; a count of zero leaves the state alone.
// in_i.ready is high only while no command is in progress; one command is
// worked on at a time. A finished result sits in an output register, so the
// next command is accepted while it waits; if the receiver stalls, a later
// draw holds at its end until the register frees. Reset clears the state
// to zero and empties the output register.
module lcg64_random_generator_with_jump_core
  import lcg64_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  lcg64_in_if.sink           in_i,
  lcg64_out_if.source        out_o
);

  typedef enum logic [6:0] {
    ST_IDLE    = 7'b0000001,
    ST_STEP    = 7'b0000010,
    ST_BOUND   = 7'b0000100,
    ST_JSTATE  = 7'b0001000,
    ST_JADD    = 7'b0010000,
    ST_JMUL    = 7'b0100000,
    ST_DELIVER = 7'b1000000
  } fsm_e;

  fsm_e        fsm_q, fsm_d;
  cmd_e        cmd_q, cmd_d, in_cmd;
  logic        issued_q, issued_d;
  logic [1:0]  steps_q, steps_d;
  logic [63:0] state_q, state_d;
  logic [31:0] seed_q, seed_d;
  logic [31:0] limit_q, limit_d;
  logic [63:0] count_q, count_d;
  logic [63:0] jmul_q, jmul_d;
  logic [63:0] jadd_q, jadd_d;
  logic [31:0] first_q, first_d;
  logic [63:0] res_q, res_d;
  logic        out_valid_q, out_valid_d;
  logic [63:0] out_data_q, out_data_d;

  logic        in_fire, need_op, out_free;
  logic [31:0] res_hi, mix_rot;
  mac_req_t    mac_req;
  mac_rsp_t    mac_rsp;

  assign in_i.ready = (fsm_q == ST_IDLE);
  assign in_fire    = in_i.valid && in_i.ready;
  assign in_cmd     = cmd_e'(in_i.command);
  assign out_free   = !out_valid_q || out_o.ready;

  assign res_hi  = mac_rsp.result[63:32];
  assign mix_rot = {res_hi[31-RotLeft:0], res_hi[31:32-RotLeft]};

  // Steer operands into the shared multiply-add unit
  always_comb begin
    mac_req.a = '0;
    mac_req.b = '0;
    mac_req.c = '0;
    need_op   = 1'b0;
    case (fsm_q)
      ST_STEP: begin
        mac_req.a = state_q;
        mac_req.b = LcgMul;
        mac_req.c = LcgAdd;
        need_op   = 1'b1;
      end
      ST_BOUND: begin
        mac_req.a = {32'd0, state_q[63:32]};
        mac_req.b = {32'd0, limit_q};
        need_op   = 1'b1;
      end
      ST_JSTATE: begin
        mac_req.a = state_q;
        mac_req.b = jmul_q;
        mac_req.c = jadd_q;
        need_op   = count_q[0];
      end
      ST_JADD: begin
        mac_req.a = jadd_q;
        mac_req.b = jmul_q;
        mac_req.c = jadd_q;
        need_op   = 1'b1;
      end
      ST_JMUL: begin
        mac_req.a = jmul_q;
        mac_req.b = jmul_q;
        need_op   = 1'b1;
      end
      default: ;
    endcase
    mac_req.start = need_op && !issued_q;
  end

  lcg64_mac u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mac_req),
    .rsp_o  (mac_rsp)
  );

  // Sequence the commands
  always_comb begin
    fsm_d    = fsm_q;
    cmd_d    = cmd_q;
    issued_d = issued_q;
    steps_d  = steps_q;
    state_d  = state_q;
    seed_d   = seed_q;
    limit_d  = limit_q;
    count_d  = count_q;
    jmul_d   = jmul_q;
    jadd_d   = jadd_q;
    first_d  = first_q;
    res_d    = res_q;

    if (mac_req.start) issued_d = 1'b1;

    case (fsm_q)
      ST_IDLE: begin
        if (in_fire) begin
          cmd_d   = in_cmd;
          seed_d  = in_i.seed_word;
          limit_d = in_i.range_limit;
          case (in_cmd)
            CMD_SEED: state_d = {32'd0, in_i.seed_word};
            CMD_SEED_MORE: begin
              steps_d = state_q[63] ? 2'd2 : 2'd1;
              fsm_d   = ST_STEP;
            end
            CMD_DRAW32, CMD_BOUNDED: begin
              steps_d = 2'd1;
              fsm_d   = ST_STEP;
            end
            CMD_DRAW64: begin
              steps_d = 2'd2;
              fsm_d   = ST_STEP;
            end
            CMD_JUMP: begin
              count_d = in_i.jump_count;
              jmul_d  = LcgMul;
              jadd_d  = LcgAdd;
              fsm_d   = ST_JSTATE;
            end
            default: ;
          endcase
        end
      end

      ST_STEP: begin
        if (mac_rsp.done) begin
          issued_d = 1'b0;
          state_d  = mac_rsp.result;
          first_d  = res_hi;
          steps_d  = steps_q - 2'd1;
          if (steps_q == 2'd1) begin
            case (cmd_q)
              CMD_SEED_MORE: begin
                state_d = {res_hi, mac_rsp.result[31:0] + (mix_rot ^ seed_q)};
                fsm_d   = ST_IDLE;
              end
              CMD_DRAW32: begin
                res_d = {32'd0, res_hi};
                fsm_d = ST_DELIVER;
              end
              CMD_DRAW64: begin
                res_d = {first_q, res_hi};
                fsm_d = ST_DELIVER;
              end
              CMD_BOUNDED: fsm_d = ST_BOUND;
              default:     fsm_d = ST_IDLE;
            endcase
          end
        end
      end

      ST_BOUND: begin
        if (mac_rsp.done) begin
          issued_d = 1'b0;
          res_d    = {32'd0, res_hi};
          fsm_d    = ST_DELIVER;
        end
      end

      // Apply the current power when its count bit is set
      ST_JSTATE: begin
        if (count_q == 64'd0) begin
          fsm_d = ST_IDLE;
        end else if (!count_q[0]) begin
          fsm_d = ST_JADD;
        end else if (mac_rsp.done) begin
          issued_d = 1'b0;
          state_d  = mac_rsp.result;
          fsm_d    = (count_q[63:1] == 63'd0) ? ST_IDLE : ST_JADD;
        end
      end

      ST_JADD: begin
        if (mac_rsp.done) begin
          issued_d = 1'b0;
          jadd_d   = mac_rsp.result;
          fsm_d    = ST_JMUL;
        end
      end

      ST_JMUL: begin
        if (mac_rsp.done) begin
          issued_d = 1'b0;
          jmul_d   = mac_rsp.result;
          count_d  = {1'b0, count_q[63:1]};
          fsm_d    = ST_JSTATE;
        end
      end

      ST_DELIVER: if (out_free) fsm_d = ST_IDLE;

      default: fsm_d = ST_IDLE;
    endcase
  end

  // Hold the result until the receiver takes it
  always_comb begin
    out_valid_d = out_valid_q && !out_o.ready;
    out_data_d  = out_data_q;
    if (fsm_q == ST_DELIVER && out_free) begin
      out_valid_d = 1'b1;
      out_data_d  = res_q;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.random_value = out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fsm_q       <= ST_IDLE;
      issued_q    <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= '0;
    end else begin
      fsm_q       <= fsm_d;
      issued_q    <= issued_d;
      out_valid_q <= out_valid_d;
      state_q     <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q      <= cmd_d;
    steps_q    <= steps_d;
    seed_q     <= seed_d;
    limit_q    <= limit_d;
    count_q    <= count_d;
    jmul_q     <= jmul_d;
    jadd_q     <= jadd_d;
    first_q    <= first_d;
    res_q      <= res_d;
    out_data_q <= out_data_d;
  end

  a_done_needs_issue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mac_rsp.done |-> issued_q)
    else $error("multiply-add result with no operation issued");

  a_idle_not_issued: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.ready |-> !issued_q)
    else $error("ready while an operation is outstanding");

  a_deliver_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fsm_q == ST_DELIVER && out_free) |=> (out_valid_q && out_data_q == $past(res_q)))
    else $error("result not loaded into output register");

  a_step_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fsm_q == ST_STEP) |-> (steps_q != 2'd0))
    else $error("state step with no steps left");

endmodule
